// ===== sv/apce_pkg.sv =====
`timescale 1ns / 1ps
// apce_pkg: types, codes and constants for the aux port command exchange
// no dependencies; imported by every module of the block
package apce_pkg;

  localparam int TIMER_BITS = 24;
  localparam int CFG_BITS   = 24;

  localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = CFG_BITS'(500);

  localparam logic [7:0] BYTE_AUX_PREFIX = 8'hd4;
  localparam logic [7:0] BYTE_ACK        = 8'hfa;
  localparam logic [7:0] BYTE_HEADER     = 8'h0a;
  localparam logic [7:0] BYTE_LEN_BAD    = 8'hff;
  localparam logic [7:0] LEN_WITH_PARAM  = 8'd4;
  localparam logic [7:0] PKT_LEN_PARAM   = 8'd2;
  localparam logic [7:0] PKT_LEN_PLAIN   = 8'd1;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_TICK      = 2'd1,
    OP_BUF_EMPTY = 2'd2,
    OP_BYTE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_CMD  = 3'd1,
    PH_WAIT_DATA = 3'd2,
    PH_WAIT_ACK  = 3'd3,
    PH_WAIT_RESP = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_RESP  = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    FAIL_NONE        = 4'd0,
    FAIL_WRITE_TMO   = 4'd1,
    FAIL_ACK_TMO     = 4'd2,
    FAIL_BAD_ACK     = 4'd3,
    FAIL_RESP_TMO    = 4'd4,
    FAIL_NOT_AUX     = 4'd5,
    FAIL_BAD_HEADER  = 4'd6,
    FAIL_BAD_LENGTH  = 4'd7,
    FAIL_CMD_ECHO    = 4'd8,
    FAIL_PARAM_ECHO  = 4'd9
  } fail_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] cmd_code;
    logic [7:0] cmd_param;
    logic       with_param;
    logic [7:0] rx_data;
    logic       rx_from_aux;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic       to_command_port;
    logic [7:0] out_byte;
    logic [7:0] resp_index;
    logic       resp_last;
    fail_t      fail_code;
  } res_t;

endpackage

// ===== sv/apce_step.sv =====
`timescale 1ns / 1ps
// apce_step: exchange state and the per-item update logic
// depends on apce_pkg
module apce_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  apce_pkg::item_t                     item,
  input  logic [apce_pkg::CFG_BITS-1:0]       timeout_ticks,
  output logic                                res_valid,
  output apce_pkg::res_t                      res
);
  import apce_pkg::*;

  phase_t                phase, phase_next;
  logic [1:0]            send_index, send_index_next;
  logic [7:0]            recv_index, recv_index_next;
  logic [7:0]            reply_length, reply_length_next;
  logic [7:0]            held_command, held_command_next;
  logic [7:0]            held_param, held_param_next;
  logic                  held_with_param, held_with_param_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;

  logic       timed_out;
  fail_t      tmo_code;
  logic [7:0] packet_byte;
  logic       ack_ok;
  logic       ack_done;
  fail_t      resp_code;
  logic       resp_last;

  // a wait ends on the tick that finds the limit reached, or the timer saturated
  assign timed_out = (32'(wait_timer) >= 32'(timeout_ticks)) || (&wait_timer);

  always_comb begin
    case (phase) inside
      PH_WAIT_ACK:  tmo_code = FAIL_ACK_TMO;
      PH_WAIT_RESP: tmo_code = FAIL_RESP_TMO;
      default:      tmo_code = FAIL_WRITE_TMO;
    endcase
  end

  always_comb begin
    case (send_index)
      2'd0:    packet_byte = BYTE_HEADER;
      2'd1:    packet_byte = held_with_param ? PKT_LEN_PARAM : PKT_LEN_PLAIN;
      2'd2:    packet_byte = held_command;
      default: packet_byte = held_param;
    endcase
  end

  assign ack_ok   = item.rx_from_aux && (item.rx_data == BYTE_ACK);
  assign ack_done = send_index >= (held_with_param ? 2'd3 : 2'd2);

  // response checks, aux source first
  always_comb begin
    if (!item.rx_from_aux) begin
      resp_code = FAIL_NOT_AUX;
    end else if (recv_index == 8'd0 && item.rx_data != BYTE_HEADER) begin
      resp_code = FAIL_BAD_HEADER;
    end else if (recv_index == 8'd1 && (item.rx_data == BYTE_LEN_BAD ||
               (held_with_param && item.rx_data != LEN_WITH_PARAM))) begin
      resp_code = FAIL_BAD_LENGTH;
    end else if (recv_index == 8'd2 && item.rx_data != held_command) begin
      resp_code = FAIL_CMD_ECHO;
    end else if (recv_index == 8'd3 && held_with_param && item.rx_data != held_param) begin
      resp_code = FAIL_PARAM_ECHO;
    end else begin
      resp_code = FAIL_NONE;
    end
  end

  assign resp_last = (recv_index >= 8'd2) &&
                     ({1'b0, recv_index} >= ({1'b0, reply_length} + 9'd1));

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (item.opcode)
      OP_START: begin
        if (phase == PH_IDLE) phase_next = PH_WAIT_CMD;
      end
      OP_TICK: begin
        if (phase != PH_IDLE && timed_out) phase_next = PH_IDLE;
      end
      OP_BUF_EMPTY: begin
        if (phase == PH_WAIT_CMD)       phase_next = PH_WAIT_DATA;
        else if (phase == PH_WAIT_DATA) phase_next = PH_WAIT_ACK;
      end
      OP_BYTE: begin
        if (phase == PH_WAIT_ACK) begin
          if (!ack_ok)       phase_next = PH_IDLE;
          else if (ack_done) phase_next = PH_WAIT_RESP;
          else               phase_next = PH_WAIT_CMD;
        end else if (phase == PH_WAIT_RESP) begin
          if (resp_code != FAIL_NONE || resp_last) phase_next = PH_IDLE;
        end
      end
      default: phase_next = phase;
    endcase
  end

  // result and data registers
  always_comb begin
    res_valid            = 1'b0;
    res                  = '0;
    send_index_next      = send_index;
    recv_index_next      = recv_index;
    reply_length_next    = reply_length;
    held_command_next    = held_command;
    held_param_next      = held_param;
    held_with_param_next = held_with_param;
    wait_timer_next      = wait_timer;
    unique case (item.opcode)
      OP_START: begin
        if (phase == PH_IDLE) begin
          held_command_next    = item.cmd_code;
          held_param_next      = item.cmd_param;
          held_with_param_next = item.with_param;
          send_index_next      = '0;
          recv_index_next      = '0;
          reply_length_next    = '0;
          wait_timer_next      = '0;
        end
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (timed_out) begin
            res_valid       = 1'b1;
            res.kind        = KIND_FAIL;
            res.fail_code   = tmo_code;
            wait_timer_next = '0;
          end else begin
            wait_timer_next = wait_timer + TIMER_BITS'(1);
          end
        end
      end
      OP_BUF_EMPTY: begin
        if (phase == PH_WAIT_CMD) begin
          res_valid           = 1'b1;
          res.kind            = KIND_WRITE;
          res.to_command_port = 1'b1;
          res.out_byte        = BYTE_AUX_PREFIX;
          wait_timer_next     = '0;
        end else if (phase == PH_WAIT_DATA) begin
          res_valid       = 1'b1;
          res.kind        = KIND_WRITE;
          res.out_byte    = packet_byte;
          wait_timer_next = '0;
        end
      end
      OP_BYTE: begin
        if (phase == PH_WAIT_ACK) begin
          wait_timer_next = '0;
          if (!ack_ok) begin
            res_valid     = 1'b1;
            res.kind      = KIND_FAIL;
            res.fail_code = FAIL_BAD_ACK;
          end else if (ack_done) begin
            recv_index_next = '0;
          end else begin
            send_index_next = send_index + 2'd1;
          end
        end else if (phase == PH_WAIT_RESP) begin
          wait_timer_next = '0;
          res_valid       = 1'b1;
          if (resp_code != FAIL_NONE) begin
            res.kind      = KIND_FAIL;
            res.fail_code = resp_code;
          end else begin
            res.kind       = KIND_RESP;
            res.out_byte   = item.rx_data;
            res.resp_index = recv_index;
            res.resp_last  = resp_last;
            if (recv_index == 8'd1) reply_length_next = item.rx_data;
            if (!resp_last)         recv_index_next   = recv_index + 8'd1;
          end
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      send_index      <= '0;
      recv_index      <= '0;
      reply_length    <= '0;
      held_command    <= '0;
      held_param      <= '0;
      held_with_param <= 1'b0;
      wait_timer      <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      send_index      <= send_index_next;
      recv_index      <= recv_index_next;
      reply_length    <= reply_length_next;
      held_command    <= held_command_next;
      held_param      <= held_param_next;
      held_with_param <= held_with_param_next;
      wait_timer      <= wait_timer_next;
    end
  end

endmodule

// ===== sv/apce_outreg.sv =====
`timescale 1ns / 1ps
// apce_outreg: result register between the update logic and the output channel
// depends on apce_pkg
module apce_outreg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  apce_pkg::res_t  res_in,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output apce_pkg::res_t  res_q
);
  import apce_pkg::*;

  // free when empty or when the held result leaves this cycle
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

// ===== sv/aux_port_command_exchange.sv =====
`timescale 1ns / 1ps
// aux_port_command_exchange: host-side command/response sequencer for an aux port device
// depends on apce_pkg, apce_step, apce_outreg
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | cfg_data (timeout_ticks, 24 bit)
//  in      | in_valid / in_ready    | opcode cmd_code cmd_param with_param rx_data rx_from_aux
//  out     | out_valid / out_ready  | out_kind to_command_port out_byte resp_index
//          |                        | resp_last fail_code
//
// one item per cycle sustained while the result register has room; a transfer in lands in the
// input register, the update logic runs on it once the result register has room, and the
// result (if any) is loaded into the result register and shows on the out channel from there
// synchronous active-high reset returns to idle with timeout_ticks = 500
// the update stage advances only when the result register is free or being
// drained; with out_ready low and a result held, one more item waits in the
// input register and in_ready then drops
module aux_port_command_exchange (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apce_pkg::CFG_BITS-1:0]  cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [7:0]                     cmd_code,
  input  logic [7:0]                     cmd_param,
  input  logic                           with_param,
  input  logic [7:0]                     rx_data,
  input  logic                           rx_from_aux,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic                           to_command_port,
  output logic [7:0]                     out_byte,
  output logic [7:0]                     resp_index,
  output logic                           resp_last,
  output logic [3:0]                     fail_code
);
  import apce_pkg::*;

  logic [CFG_BITS-1:0] timeout_ticks;
  logic                item_valid;
  item_t               item_q;
  logic                fire;
  logic                space;
  logic                res_valid;
  res_t                res;
  res_t                res_q;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  // input register; the update stage fires whenever it holds an item and the
  // result register has room, whether or not the item makes a result
  assign fire     = item_valid && space;
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.opcode      <= op_t'(opcode);
      item_q.cmd_code    <= cmd_code;
      item_q.cmd_param   <= cmd_param;
      item_q.with_param  <= with_param;
      item_q.rx_data     <= rx_data;
      item_q.rx_from_aux <= rx_from_aux;
    end
  end

  // exchange state and per-item update
  apce_step u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (item_q),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result register
  apce_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .res_in    (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign out_kind        = res_q.kind;
  assign to_command_port = res_q.to_command_port;
  assign out_byte        = res_q.out_byte;
  assign resp_index      = res_q.resp_index;
  assign resp_last       = res_q.resp_last;
  assign fail_code       = res_q.fail_code;

endmodule

// ===== sv/apce_checker.sv =====
`timescale 1ns / 1ps
// apce_checker: port-level checks on the exchange sequencer, bound to the top level
// depends on apce_pkg and aux_port_command_exchange
module apce_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       to_command_port,
  input logic [7:0] out_byte,
  input logic [7:0] resp_index,
  input logic       resp_last,
  input logic [3:0] fail_code
);
  import apce_pkg::*;

  // a held result stays offered until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // a command-port write always carries the aux prefix
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_WRITE && to_command_port |-> out_byte == BYTE_AUX_PREFIX)
    else $error("command port write without aux prefix");

  // failures carry a code and no payload; writes and responses carry no code
  a_fail_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_FAIL |->
      fail_code != FAIL_NONE && out_byte == 8'd0 && !resp_last && !to_command_port)
    else $error("malformed failure result");

  // the final response byte sits at index two or later
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_RESP && resp_last |->
      resp_index >= 8'd2 && fail_code == FAIL_NONE)
    else $error("final response byte at a bad index");

endmodule

bind aux_port_command_exchange apce_checker u_apce_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .to_command_port (to_command_port),
  .out_byte        (out_byte),
  .resp_index      (resp_index),
  .resp_last       (resp_last),
  .fail_code       (fail_code)
);

// ===== dv/tb_aux_port_command_exchange.sv =====
`timescale 1ns / 1ps
// tb_aux_port_command_exchange: self-checking bench for the aux port command exchange
// depends on apce_pkg and aux_port_command_exchange; predicts every result in-bench
// directed table first, then randomised exchanges under several timeout settings
module tb_aux_port_command_exchange;
  import apce_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 6;      // input and result registers plus margin
  localparam int RUN_ITEMS     = 1300;
  localparam int N_SETTINGS    = 7;
  localparam logic [TIMER_BITS-1:0] TIMER_TOP = {TIMER_BITS{1'b1}};

  // how a directed row is checked: predictor, nothing expected, or typed result
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_RES
  } chk_t;

  typedef struct {
    item_t it;
    chk_t  chk;
    res_t  res;
  } dir_row_t;

  // ---------------------------------------------------------------- dut side
  logic                clk;
  logic                rst             = 1'b1;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data        = '0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [1:0]          opcode          = '0;
  logic [7:0]          cmd_code        = '0;
  logic [7:0]          cmd_param       = '0;
  logic                with_param      = 1'b0;
  logic [7:0]          rx_data         = '0;
  logic                rx_from_aux     = 1'b0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [1:0]          out_kind;
  logic                to_command_port;
  logic [7:0]          out_byte;
  logic [7:0]          resp_index;
  logic                resp_last;
  logic [3:0]          fail_code;

  aux_port_command_exchange u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .cmd_code        (cmd_code),
    .cmd_param       (cmd_param),
    .with_param      (with_param),
    .rx_data         (rx_data),
    .rx_from_aux     (rx_from_aux),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .to_command_port (to_command_port),
    .out_byte        (out_byte),
    .resp_index      (resp_index),
    .resp_last       (resp_last),
    .fail_code       (fail_code)
  );

  // ------------------------------------------------------- predicted state
  // bench copy of the sequencer, stepped once per accepted input transfer
  phase_t              xchg_phase = PH_IDLE;
  logic [1:0]          pkt_pos    = '0;      // which packet byte is going out
  logic [7:0]          rsp_pos    = '0;      // index of the next response byte
  logic [7:0]          rsp_len    = '0;      // length byte of the response
  logic [7:0]          held_cmd   = '0;
  logic [7:0]          held_par   = '0;
  logic                held_wp    = 1'b0;
  logic [TIMER_BITS-1:0] waited   = '0;      // ticks spent in the current wait
  logic [CFG_BITS-1:0] wait_limit = TIMEOUT_RESET;

  res_t expected_q[$];   // results still owed by the block, oldest first
  int   mismatches = 0;
  int   cycles     = 0;
  int   live_items = 0;  // accepted items that changed state or gave a result
  bit   in_quiet   = 1'b0;
  bit   out_quiet  = 1'b0;

  // clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic item_t mk_item(op_t op, logic [7:0] c, logic [7:0] p, logic w,
                                    logic [7:0] d, logic a);
    item_t it;
    it.opcode      = op;
    it.cmd_code    = c;
    it.cmd_param   = p;
    it.with_param  = w;
    it.rx_data     = d;
    it.rx_from_aux = a;
    return it;
  endfunction

  // given opcode, every other field random (don't-care fields still toggle)
  function automatic item_t rand_item(op_t op);
    return mk_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
  endfunction

  function automatic res_t mk_res(kind_t k, logic port, logic [7:0] b, logic [7:0] idx,
                                  logic last, fail_t code);
    res_t r;
    r.kind            = k;
    r.to_command_port = port;
    r.out_byte        = b;
    r.resp_index      = idx;
    r.resp_last       = last;
    r.fail_code       = code;
    return r;
  endfunction

  function automatic dir_row_t row(item_t it, chk_t c = CHK_PRED, res_t r = '0);
    dir_row_t d;
    d.it  = it;
    d.chk = c;
    d.res = r;
    return d;
  endfunction

  // step the bench copy by one item; returns 1 unless the item was ignored
  function automatic bit predict_exchange(input item_t it, output bit has_res,
                                          output res_t r);
    bit         acted;
    bit         is_last;
    fail_t      why;
    logic [7:0] b;
    acted   = 1'b1;
    has_res = 1'b0;
    r       = '0;
    why     = FAIL_NONE;
    case (it.opcode)
      OP_START: begin
        // a start while busy is dropped
        if (xchg_phase != PH_IDLE) begin
          acted = 1'b0;
        end else begin
          held_cmd   = it.cmd_code;
          held_par   = it.cmd_param;
          held_wp    = it.with_param;
          pkt_pos    = '0;
          rsp_pos    = '0;
          rsp_len    = '0;
          waited     = '0;
          xchg_phase = PH_WAIT_CMD;
        end
      end
      OP_TICK: begin
        // saturation of the tick counter coincides with the top timeout setting
        if (xchg_phase == PH_IDLE) begin
          acted = 1'b0;
        end else if (waited >= wait_limit || waited == TIMER_TOP) begin
          if (xchg_phase == PH_WAIT_ACK) why = FAIL_ACK_TMO;
          else if (xchg_phase == PH_WAIT_RESP) why = FAIL_RESP_TMO;
          else why = FAIL_WRITE_TMO;
        end else begin
          waited = waited + 1'b1;
        end
      end
      OP_BUF_EMPTY: begin
        if (xchg_phase == PH_WAIT_CMD) begin
          xchg_phase = PH_WAIT_DATA;
          waited     = '0;
          has_res    = 1'b1;
          r = mk_res(KIND_WRITE, 1'b1, BYTE_AUX_PREFIX, 8'h00, 1'b0, FAIL_NONE);
        end else if (xchg_phase == PH_WAIT_DATA) begin
          case (pkt_pos)
            2'd0:    b = BYTE_HEADER;
            2'd1:    b = held_wp ? PKT_LEN_PARAM : PKT_LEN_PLAIN;
            2'd2:    b = held_cmd;
            default: b = held_par;
          endcase
          xchg_phase = PH_WAIT_ACK;
          waited     = '0;
          has_res    = 1'b1;
          r = mk_res(KIND_WRITE, 1'b0, b, 8'h00, 1'b0, FAIL_NONE);
        end else begin
          acted = 1'b0;
        end
      end
      default: begin
        if (xchg_phase == PH_WAIT_ACK) begin
          if (!it.rx_from_aux || it.rx_data != BYTE_ACK) begin
            why = FAIL_BAD_ACK;
          end else begin
            waited = '0;
            if (pkt_pos >= (held_wp ? 2'd3 : 2'd2)) begin
              xchg_phase = PH_WAIT_RESP;
              rsp_pos    = '0;
            end else begin
              pkt_pos    = pkt_pos + 1'b1;
              xchg_phase = PH_WAIT_CMD;
            end
          end
        end else if (xchg_phase == PH_WAIT_RESP) begin
          // aux origin is checked ahead of the byte value
          if (!it.rx_from_aux) why = FAIL_NOT_AUX;
          else if (rsp_pos == 8'd0 && it.rx_data != BYTE_HEADER) why = FAIL_BAD_HEADER;
          else if (rsp_pos == 8'd1 && (it.rx_data == BYTE_LEN_BAD ||
                                       (held_wp && it.rx_data != LEN_WITH_PARAM)))
            why = FAIL_BAD_LENGTH;
          else if (rsp_pos == 8'd2 && it.rx_data != held_cmd) why = FAIL_CMD_ECHO;
          else if (rsp_pos == 8'd3 && held_wp && it.rx_data != held_par)
            why = FAIL_PARAM_ECHO;
          else begin
            if (rsp_pos == 8'd1) rsp_len = it.rx_data;
            // never ends before index 2, so a zero length still gives three bytes
            is_last = (rsp_pos >= 8'd2) && ({1'b0, rsp_pos} >= {1'b0, rsp_len} + 9'd1);
            waited  = '0;
            has_res = 1'b1;
            r = mk_res(KIND_RESP, 1'b0, it.rx_data, rsp_pos, is_last, FAIL_NONE);
            if (is_last) xchg_phase = PH_IDLE;
            else rsp_pos = rsp_pos + 1'b1;
          end
        end else begin
          acted = 1'b0;
        end
      end
    endcase
    if (why != FAIL_NONE) begin
      xchg_phase = PH_IDLE;
      waited     = '0;
      has_res    = 1'b1;
      r = mk_res(KIND_FAIL, 1'b0, 8'h00, 8'h00, 1'b0, why);
    end
    return acted;
  endfunction

  // one input transfer after a random gap; the expectation is queued on acceptance
  task automatic send_item(input item_t it, input chk_t chk = CHK_PRED,
                           input res_t typed = '0);
    int   gap;
    bit   has_res;
    res_t r;
    if ($urandom_range(0, 99) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= it.opcode;
    cmd_code    <= it.cmd_code;
    cmd_param   <= it.cmd_param;
    with_param  <= it.with_param;
    rx_data     <= it.rx_data;
    rx_from_aux <= it.rx_from_aux;
    do @(posedge clk); while (!in_ready);
    if (predict_exchange(it, has_res, r)) live_items++;
    case (chk)
      CHK_PRED: if (has_res) expected_q.push_back(r);
      CHK_RES:  expected_q.push_back(typed);
      default:  ;
    endcase
  endtask

  // sender stops and waits until every owed result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ticks before a wait ends; now and then just enough to time out
  function automatic int draw_ticks();
    int base;
    base = (wait_limit < 3) ? int'(wait_limit) : 3;
    if (wait_limit <= 40 && $urandom_range(0, 11) == 0) return int'(wait_limit) + 1;
    return $urandom_range(0, base);
  endfunction

  // ticks and the odd stray item ahead of the next real event
  task automatic wait_out();
    int n;
    n = draw_ticks();
    repeat (n) send_item(rand_item(OP_TICK));
    if ($urandom_range(0, 19) == 0) send_item(rand_item(op_t'($urandom_range(0, 3))));
  endtask

  // one mostly well-formed exchange with random content, dropped once the block is idle
  task automatic run_exchange();
    item_t      st;
    logic [7:0] len_b;
    logic [7:0] b;
    logic       aux;
    int         n_pkt;
    int         i;
    st = rand_item(OP_START);
    send_item(st);
    if ($urandom_range(0, 9) == 0) send_item(rand_item(OP_START));
    n_pkt = st.with_param ? 4 : 3;
    for (i = 0; i < n_pkt; i++) begin
      wait_out();
      send_item(rand_item(OP_BUF_EMPTY));
      if (xchg_phase == PH_IDLE) return;
      wait_out();
      send_item(rand_item(OP_BUF_EMPTY));
      if (xchg_phase == PH_IDLE) return;
      wait_out();
      b   = BYTE_ACK;
      aux = 1'b1;
      if ($urandom_range(0, 24) == 0) begin
        b   = 8'($urandom_range(0, 255));
        aux = 1'($urandom_range(0, 1));
      end
      send_item(mk_item(OP_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), b, aux));
      if (xchg_phase == PH_IDLE) return;
    end
    // response: mostly short, now and then long or malformed
    if (st.with_param) begin
      len_b = ($urandom_range(0, 9) != 0) ? LEN_WITH_PARAM : 8'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 19))
        0:       len_b = BYTE_LEN_BAD;
        1:       len_b = 8'($urandom_range(0, 254));
        default: len_b = 8'($urandom_range(0, 6));
      endcase
    end
    for (i = 0; i < 300; i++) begin
      wait_out();
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) != 0) begin
        case (i)
          0: b = BYTE_HEADER;
          2: b = st.cmd_code;
          3: if (st.with_param) b = st.cmd_param;
          default: ;
        endcase
      end
      if (i == 1) b = len_b;
      aux = ($urandom_range(0, 32) != 0);
      send_item(mk_item(OP_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), b, aux));
      if (xchg_phase == PH_IDLE) return;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // result side: random stall before each transfer, with quiet stretches
  initial begin : result_sink
    int stall;
    forever begin
      if ($urandom_range(0, 99) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // every result transfer is checked against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {out_kind, to_command_port, out_byte, resp_index, resp_last, fail_code};
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h code %0d",
                                  out_kind, out_byte, fail_code));
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 8'(got.kind), 8'(want.kind));
        check_field("to_command_port", 8'(got.to_command_port), 8'(want.to_command_port));
        check_field("out_byte", got.out_byte, want.out_byte);
        check_field("resp_index", got.resp_index, want.resp_index);
        check_field("resp_last", 8'(got.resp_last), 8'(want.resp_last));
        check_field("fail_code", 8'(got.fail_code), 8'(want.fail_code));
      end
    end
  end

  initial begin : stimulus
    dir_row_t            dir_rows[$];
    logic [CFG_BITS-1:0] tmo_plan[N_SETTINGS];
    int                  goal;
    int                  p;

    // reset held at the start, once
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle block ignores a tick
    dir_rows.push_back(row(mk_item(OP_TICK, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0), CHK_NONE));
    // plain exchange, command 00, reply announces length ff
    dir_rows.push_back(row(mk_item(OP_START, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0), CHK_NONE));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0), CHK_RES,
                           mk_res(KIND_WRITE, 1'b1, BYTE_AUX_PREFIX, 8'h00, 1'b0, FAIL_NONE)));
    // a byte while waiting for the data write is ignored
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'h00, 8'h00, 1'b0, BYTE_ACK, 1'b1), CHK_NONE));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0), CHK_RES,
                           mk_res(KIND_WRITE, 1'b0, BYTE_HEADER, 8'h00, 1'b0, FAIL_NONE)));
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'h00, 8'h00, 1'b0, BYTE_ACK, 1'b1), CHK_NONE));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0)));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0), CHK_RES,
                           mk_res(KIND_WRITE, 1'b0, PKT_LEN_PLAIN, 8'h00, 1'b0, FAIL_NONE)));
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'h00, 8'h00, 1'b0, BYTE_ACK, 1'b1)));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0)));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0)));
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'h00, 8'h00, 1'b0, BYTE_ACK, 1'b1)));
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'h00, 8'h00, 1'b0, BYTE_HEADER, 1'b1), CHK_RES,
                           mk_res(KIND_RESP, 1'b0, BYTE_HEADER, 8'h00, 1'b0, FAIL_NONE)));
    // length ff would need index 256
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'h00, 8'h00, 1'b0, BYTE_LEN_BAD, 1'b1), CHK_RES,
                           mk_res(KIND_FAIL, 1'b0, 8'h00, 8'h00, 1'b0, FAIL_BAD_LENGTH)));
    // parameter exchange ff/ff, second start dropped, ack not from the aux source
    dir_rows.push_back(row(mk_item(OP_START, 8'hff, 8'hff, 1'b1, 8'h00, 1'b0), CHK_NONE));
    dir_rows.push_back(row(mk_item(OP_START, 8'h5a, 8'ha5, 1'b0, 8'hff, 1'b1), CHK_NONE));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1)));
    dir_rows.push_back(row(mk_item(OP_BUF_EMPTY, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1)));
    dir_rows.push_back(row(mk_item(OP_BYTE, 8'hff, 8'hff, 1'b1, BYTE_ACK, 1'b0), CHK_RES,
                           mk_res(KIND_FAIL, 1'b0, 8'h00, 8'h00, 1'b0, FAIL_BAD_ACK)));

    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].chk, dir_rows[k].res);

    // timeout settings: the top value and a limit of one, tight ones that time out often, reset value
    tmo_plan[0] = CFG_BITS'(1);
    tmo_plan[1] = {CFG_BITS{1'b1}};
    tmo_plan[2] = CFG_BITS'(2);
    tmo_plan[3] = CFG_BITS'($urandom_range(3, 40));
    tmo_plan[4] = TIMEOUT_RESET;
    tmo_plan[5] = CFG_BITS'(5);
    tmo_plan[6] = CFG_BITS'(1);

    for (p = 0; p < N_SETTINGS; p++) begin
      // register written only with nothing in flight
      settle();
      cfg_valid <= 1'b1;
      cfg_data  <= tmo_plan[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid  <= 1'b0;
      wait_limit = tmo_plan[p];
      goal = live_items + RUN_ITEMS / N_SETTINGS;
      while (live_items < goal) run_exchange();
    end

    settle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== aux_port_command_exchange.f =====
sv/apce_pkg.sv
sv/apce_step.sv
sv/apce_outreg.sv
sv/aux_port_command_exchange.sv
sv/apce_checker.sv
dv/tb_aux_port_command_exchange.sv
